// ===== sv/equirect_to_cubemap_lookup_macros.svh =====
// assertion macros for the equirect to cubemap lookup checker
// no dependencies; included by the checker file
`ifndef EQUIRECT_TO_CUBEMAP_LOOKUP_MACROS_SVH
`define EQUIRECT_TO_CUBEMAP_LOOKUP_MACROS_SVH

// same-cycle implication, masked while reset is held
`define E2C_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked during reset too
`define E2C_ASSERT_NEXT(lbl, clk, ante, cons, msg) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

// ===== sv/e2c_pkg.sv =====
// shared types, constants and the arctangent table for the lookup pipeline
// no dependencies
package e2c_pkg;

    localparam int NW         = 15;   // clamped face size
    localparam int QW         = 18;   // signed q2.16 component
    localparam int CW         = 21;   // cordic datapath
    localparam int ZW         = 18;   // angle in 2^-16 turn
    localparam int RADW       = 36;   // radicand
    localparam int ROOTW      = 18;
    localparam int REMW       = 20;
    localparam int DIV_STEPS  = QW;
    localparam int SQRT_STEPS = ROOTW;

    localparam logic [1:0] REG_FACE_SIZE   = 2'd0;
    localparam logic [1:0] REG_PANO_WIDTH  = 2'd1;
    localparam logic [1:0] REG_PANO_HEIGHT = 2'd2;

    localparam logic [2:0] FACE_POS_X = 3'd0;
    localparam logic [2:0] FACE_NEG_X = 3'd1;
    localparam logic [2:0] FACE_POS_Y = 3'd2;
    localparam logic [2:0] FACE_NEG_Y = 3'd3;
    localparam logic [2:0] FACE_POS_Z = 3'd4;
    localparam logic [2:0] FACE_NEG_Z = 3'd5;

    typedef struct packed {
        logic            vld;
        logic            neg;
        logic            ovf;
        logic [NW-2:0]   rem;
        logic [QW-1:0]   low;
        logic [QW-1:0]   quo;
    } t_div_lane;

    typedef struct packed {
        logic                   vld;
        logic [RADW-1:0]        rad;
        logic [REMW-1:0]        rem;
        logic [ROOTW-1:0]       root;
        logic signed [QW-1:0]   dx;
        logic signed [QW-1:0]   dy;
        logic signed [QW-1:0]   dz;
    } t_sqrt_word;

    typedef struct packed {
        logic                   vld;
        logic                   zero;
        logic signed [CW-1:0]   x;
        logic signed [CW-1:0]   y;
        logic signed [ZW-1:0]   z;
    } t_cordic_word;

    // arctangent of 2^-i in 2^-16 turn
    function automatic logic signed [ZW-1:0] atan_step(input int idx);
        logic signed [ZW-1:0] a;
        case (idx)
            0:       a = 18'sd8192;
            1:       a = 18'sd4836;
            2:       a = 18'sd2555;
            3:       a = 18'sd1297;
            4:       a = 18'sd651;
            5:       a = 18'sd326;
            6:       a = 18'sd163;
            7:       a = 18'sd81;
            8:       a = 18'sd41;
            9:       a = 18'sd20;
            10:      a = 18'sd10;
            11:      a = 18'sd5;
            12:      a = 18'sd3;
            13:      a = 18'sd1;
            14:      a = 18'sd1;
            default: a = 18'sd0;
        endcase
        return a;
    endfunction

endpackage

// ===== sv/e2c_div_cell.sv =====
// one restoring division step for the face coordinate quotient
// depends on e2c_pkg
module e2c_div_cell import e2c_pkg::*; (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  t_div_lane     i_lane,
    input  logic [NW-1:0] i_divisor,
    output t_div_lane     o_lane
);

    logic [NW-1:0] trial;
    logic [NW-1:0] diff;
    logic          take;
    t_div_lane     n_lane;
    t_div_lane     r_lane;

    // bring down one dividend bit and try the subtract
    always_comb begin
        trial  = {i_lane.rem, i_lane.low[QW-1]};
        diff   = trial - i_divisor;
        take   = (trial >= i_divisor);
        n_lane = i_lane;
        n_lane.rem = take ? diff[NW-2:0] : trial[NW-2:0];
        n_lane.low = {i_lane.low[QW-2:0], 1'b0};
        n_lane.quo = {i_lane.quo[QW-2:0], take};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lane <= '0;
        end else begin
            r_lane <= n_lane;
        end
    end

    assign o_lane = r_lane;

endmodule

// ===== sv/e2c_sqrt_cell.sv =====
// one digit step of the integer square root, carrying the direction along
// depends on e2c_pkg
module e2c_sqrt_cell import e2c_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_sqrt_word i_word,
    output t_sqrt_word o_word
);

    logic [REMW+1:0] cur;
    logic [REMW+1:0] trial;
    logic [REMW+1:0] diff;
    logic            take;
    t_sqrt_word      n_word;
    t_sqrt_word      r_word;

    // shift in two radicand bits and test against 4*root+1
    always_comb begin
        cur    = {i_word.rem, i_word.rad[RADW-1:RADW-2]};
        trial  = {2'b00, i_word.root, 2'b01};
        diff   = cur - trial;
        take   = (cur >= trial);
        n_word = i_word;
        n_word.rem  = take ? diff[REMW-1:0] : cur[REMW-1:0];
        n_word.root = {i_word.root[ROOTW-2:0], take};
        n_word.rad  = {i_word.rad[RADW-3:0], 2'b00};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_word <= '0;
        end else begin
            r_word <= n_word;
        end
    end

    assign o_word = r_word;

endmodule

// ===== sv/e2c_cordic_cell.sv =====
// one vectoring cordic micro-rotation with its arctangent step
// depends on e2c_pkg
module e2c_cordic_cell import e2c_pkg::*; #(
    parameter int STAGE = 0
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  t_cordic_word i_word,
    output t_cordic_word o_word
);

    logic signed [CW-1:0] xs;
    logic signed [CW-1:0] ys;
    t_cordic_word         n_word;
    t_cordic_word         r_word;

    // rotate towards the x axis, accumulating the angle
    always_comb begin
        xs     = i_word.x >>> STAGE;
        ys     = i_word.y >>> STAGE;
        n_word = i_word;
        if (!i_word.y[CW-1]) begin
            n_word.x = i_word.x + ys;
            n_word.y = i_word.y - xs;
            n_word.z = i_word.z + atan_step(STAGE);
        end else begin
            n_word.x = i_word.x - ys;
            n_word.y = i_word.y + xs;
            n_word.z = i_word.z - atan_step(STAGE);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_word <= '0;
        end else begin
            r_word <= n_word;
        end
    end

    assign o_word = r_word;

endmodule

// ===== sv/equirect_to_cubemap_lookup.sv =====
// cubemap texel to equirectangular source pixel lookup, fully pipelined.
// throughput one word per clock; busy never rises and results cannot be stalled.
// the path from start to the o_valid strobe runs through the 18-cell divider,
// the 18-cell square root and the cordic cell row.
// synchronous active-low reset clears the pipeline valid bits and loads the
// register defaults: face size 512, width 2048, height 1024.
module equirect_to_cubemap_lookup import e2c_pkg::*; #(
    parameter int MAX_FACE_SIZE   = 4096,
    parameter int MAX_PANO_WIDTH  = 8192,
    parameter int MAX_PANO_HEIGHT = 4096,
    parameter int CORDIC_STAGES   = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [2:0]  i_face,
    input  logic [11:0] i_texel_x,
    input  logic [11:0] i_texel_y,
    output logic        o_valid,
    output logic [12:0] o_src_x,
    output logic [11:0] o_src_y,
    output logic [24:0] o_src_index,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    // configuration registers
    logic [12:0] r_face_size;
    logic [13:0] r_pano_width;
    logic [12:0] r_pano_height;
    logic        cfg_wr;

    assign pready = 1'b1;
    assign busy   = 1'b0;
    assign cfg_wr = psel & penable & pwrite & pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_face_size   <= 13'd512;
            r_pano_width  <= 14'd2048;
            r_pano_height <= 13'd1024;
        end else if (cfg_wr) begin
            unique case (paddr[3:2])
                REG_FACE_SIZE:   r_face_size   <= pwdata[12:0];
                REG_PANO_WIDTH:  r_pano_width  <= pwdata[13:0];
                REG_PANO_HEIGHT: r_pano_height <= pwdata[12:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            REG_FACE_SIZE:   prdata = {19'd0, r_face_size};
            REG_PANO_WIDTH:  prdata = {18'd0, r_pano_width};
            REG_PANO_HEIGHT: prdata = {19'd0, r_pano_height};
            default:         prdata = 32'd0;
        endcase
    end

    // clamped working copies of the registers
    logic [NW-1:0] lim_n;
    logic [15:0]   lim_w;
    logic [14:0]   lim_h;

    always_comb begin
        if (r_face_size == 13'd0) begin
            lim_n = NW'(1);
        end else if ({2'b00, r_face_size} > NW'(MAX_FACE_SIZE)) begin
            lim_n = NW'(MAX_FACE_SIZE);
        end else begin
            lim_n = {2'b00, r_face_size};
        end
        if (r_pano_width == 14'd0) begin
            lim_w = 16'd1;
        end else if ({2'b00, r_pano_width} > 16'(MAX_PANO_WIDTH)) begin
            lim_w = 16'(MAX_PANO_WIDTH);
        end else begin
            lim_w = {2'b00, r_pano_width};
        end
        if (r_pano_height == 13'd0) begin
            lim_h = 15'd1;
        end else if ({2'b00, r_pano_height} > 15'(MAX_PANO_HEIGHT)) begin
            lim_h = 15'(MAX_PANO_HEIGHT);
        end else begin
            lim_h = {2'b00, r_pano_height};
        end
    end

    // dividend set-up: |2t+1-n| * 65536 + n/2
    function automatic t_div_lane div_setup(input logic [11:0] t, input logic [NW-1:0] n);
        logic signed [16:0] d;
        logic [15:0]        m;
        logic [30:0]        num;
        t_div_lane          l;
        d   = $signed({4'b0000, t, 1'b1}) - $signed({2'b00, n});
        m   = d[16] ? 16'(-d) : d[15:0];
        num = {m[14:0], 16'd0} + {17'd0, n[NW-1:1]};
        l.vld = 1'b1;
        l.neg = d[16];
        l.ovf = ({2'b00, num[30:18]} >= n);
        l.rem = {1'b0, num[30:18]};
        l.low = num[17:0];
        l.quo = '0;
        return l;
    endfunction

    logic      accept;
    t_div_lane r_div_x;
    t_div_lane r_div_y;
    logic [2:0] r_face_s0;

    assign accept = start & ~busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_div_x <= '0;
            r_div_y <= '0;
        end else if (accept) begin
            r_div_x <= div_setup(i_texel_x, lim_n);
            r_div_y <= div_setup(i_texel_y, lim_n);
        end else begin
            r_div_x.vld <= 1'b0;
            r_div_y.vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        r_face_s0 <= i_face;
    end

    // divider cell rows
    t_div_lane  w_divx [DIV_STEPS+1];
    t_div_lane  w_divy [DIV_STEPS+1];
    logic [2:0] r_face_dly [DIV_STEPS];

    assign w_divx[0] = r_div_x;
    assign w_divy[0] = r_div_y;

    genvar g;
    generate
        for (g = 0; g < DIV_STEPS; g++) begin : g_div
            e2c_div_cell u_divx (
                .i_clk    (i_clk),
                .i_rst_n  (i_rst_n),
                .i_lane   (w_divx[g]),
                .i_divisor(lim_n),
                .o_lane   (w_divx[g+1])
            );
            e2c_div_cell u_divy (
                .i_clk    (i_clk),
                .i_rst_n  (i_rst_n),
                .i_lane   (w_divy[g]),
                .i_divisor(lim_n),
                .o_lane   (w_divy[g+1])
            );
            if (g == 0) begin : g_f0
                always_ff @(posedge i_clk) r_face_dly[g] <= r_face_s0;
            end else begin : g_fn
                always_ff @(posedge i_clk) r_face_dly[g] <= r_face_dly[g-1];
            end
        end
    endgenerate

    // signed saturated coordinate from the quotient
    function automatic logic signed [QW-1:0] lane_coord(input t_div_lane l);
        logic signed [QW-1:0] c;
        if (!l.neg) begin
            c = (l.ovf || l.quo[QW-1]) ? 18'sd131071 : $signed(l.quo);
        end else if (l.ovf || (l.quo > 18'd131072)) begin
            c = -18'sd131072;
        end else begin
            c = -$signed(l.quo);
        end
        return c;
    endfunction

    function automatic logic signed [QW-1:0] neg_q(input logic signed [QW-1:0] v);
        logic signed [QW-1:0] r;
        r = (v == -18'sd131072) ? 18'sd131071 : -v;
        return r;
    endfunction

    // face table
    logic signed [QW-1:0] fx;
    logic signed [QW-1:0] fy;
    logic signed [QW-1:0] n_dx, n_dy, n_dz;
    localparam logic signed [QW-1:0] ONE = 18'sd65536;

    always_comb begin
        fx   = lane_coord(w_divx[DIV_STEPS]);
        fy   = lane_coord(w_divy[DIV_STEPS]);
        n_dx = '0;
        n_dy = '0;
        n_dz = '0;
        case (r_face_dly[DIV_STEPS-1])
            FACE_POS_X: begin n_dx = ONE;      n_dy = neg_q(fy); n_dz = neg_q(fx); end
            FACE_NEG_X: begin n_dx = -ONE;     n_dy = neg_q(fy); n_dz = fx;        end
            FACE_POS_Y: begin n_dx = fx;       n_dy = ONE;       n_dz = fy;        end
            FACE_NEG_Y: begin n_dx = fx;       n_dy = -ONE;      n_dz = neg_q(fy); end
            FACE_POS_Z: begin n_dx = fx;       n_dy = neg_q(fy); n_dz = ONE;       end
            FACE_NEG_Z: begin n_dx = neg_q(fx); n_dy = neg_q(fy); n_dz = -ONE;     end
            default: ;
        endcase
    end

    logic                 r_dir_vld;
    logic signed [QW-1:0] r_dx, r_dy, r_dz;
    logic                 r_sq_vld;
    logic signed [2*QW-1:0] r_sqx, r_sqz;
    logic signed [QW-1:0] r_sq_dx, r_sq_dy, r_sq_dz;
    t_sqrt_word           r_sum;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dir_vld <= 1'b0;
            r_sq_vld  <= 1'b0;
        end else begin
            r_dir_vld <= w_divx[DIV_STEPS].vld;
            r_sq_vld  <= r_dir_vld;
        end
    end

    // direction, squares and radicand
    always_ff @(posedge i_clk) begin
        r_dx       <= n_dx;
        r_dy       <= n_dy;
        r_dz       <= n_dz;
        r_sqx      <= r_dx * r_dx;
        r_sqz      <= r_dz * r_dz;
        r_sq_dx    <= r_dx;
        r_sq_dy    <= r_dy;
        r_sq_dz    <= r_dz;
        r_sum.vld  <= r_sq_vld & i_rst_n;
        r_sum.rad  <= RADW'(r_sqx) + RADW'(r_sqz);
        r_sum.rem  <= '0;
        r_sum.root <= '0;
        r_sum.dx   <= r_sq_dx;
        r_sum.dy   <= r_sq_dy;
        r_sum.dz   <= r_sq_dz;
    end

    // square root cell row
    t_sqrt_word w_sq [SQRT_STEPS+1];
    assign w_sq[0] = r_sum;

    generate
        for (g = 0; g < SQRT_STEPS; g++) begin : g_sqrt
            e2c_sqrt_cell u_sqrt (
                .i_clk  (i_clk),
                .i_rst_n(i_rst_n),
                .i_word (w_sq[g]),
                .o_word (w_sq[g+1])
            );
        end
    endgenerate

    // cordic entry with the half-turn pre-rotation
    t_cordic_word         w_c1 [CORDIC_STAGES+1];
    t_cordic_word         w_c2 [CORDIC_STAGES+1];
    logic signed [CW-1:0] ex, ez;

    always_comb begin
        ex = {{(CW-QW){w_sq[SQRT_STEPS].dx[QW-1]}}, w_sq[SQRT_STEPS].dx};
        ez = {{(CW-QW){w_sq[SQRT_STEPS].dz[QW-1]}}, w_sq[SQRT_STEPS].dz};
        w_c1[0].vld  = w_sq[SQRT_STEPS].vld;
        w_c1[0].zero = (ex == '0) && (ez == '0);
        if (ex[CW-1]) begin
            w_c1[0].x = -ex;
            w_c1[0].y = -ez;
            w_c1[0].z = ez[CW-1] ? -18'sd32768 : 18'sd32768;
        end else begin
            w_c1[0].x = ex;
            w_c1[0].y = ez;
            w_c1[0].z = '0;
        end
        w_c2[0].vld  = w_sq[SQRT_STEPS].vld;
        w_c2[0].x    = {{(CW-ROOTW){1'b0}}, w_sq[SQRT_STEPS].root};
        w_c2[0].y    = {{(CW-QW){w_sq[SQRT_STEPS].dy[QW-1]}}, w_sq[SQRT_STEPS].dy};
        w_c2[0].z    = '0;
        w_c2[0].zero = (w_sq[SQRT_STEPS].root == '0) && (w_sq[SQRT_STEPS].dy == '0);
    end

    // cordic cell rows for longitude and latitude
    generate
        for (g = 0; g < CORDIC_STAGES; g++) begin : g_cordic
            e2c_cordic_cell #(.STAGE(g)) u_lon (
                .i_clk  (i_clk),
                .i_rst_n(i_rst_n),
                .i_word (w_c1[g]),
                .o_word (w_c1[g+1])
            );
            e2c_cordic_cell #(.STAGE(g)) u_lat (
                .i_clk  (i_clk),
                .i_rst_n(i_rst_n),
                .i_word (w_c2[g]),
                .o_word (w_c2[g+1])
            );
        end
    endgenerate

    // turn fractions u and v, clamped to one full turn
    logic signed [ZW-1:0] a1, a2;
    logic signed [19:0]   us, vs;
    logic [16:0]          u, v;

    always_comb begin
        a1 = w_c1[CORDIC_STAGES].zero ? '0 : w_c1[CORDIC_STAGES].z;
        a2 = w_c2[CORDIC_STAGES].zero ? '0 : w_c2[CORDIC_STAGES].z;
        us = 20'sd32768 + {{2{a1[ZW-1]}}, a1};
        vs = 20'sd32768 - {{1{a2[ZW-1]}}, a2, 1'b0};
        if (us[19]) begin
            u = '0;
        end else if (us > 20'sd65536) begin
            u = 17'd65536;
        end else begin
            u = us[16:0];
        end
        if (vs[19]) begin
            v = '0;
        end else if (vs > 20'sd65536) begin
            v = 17'd65536;
        end else begin
            v = vs[16:0];
        end
    end

    logic        r_f1_vld, r_f2_vld, r_f3_vld;
    logic [32:0] r_pu;
    logic [31:0] r_pv;
    logic [16:0] px_raw;
    logic [15:0] py_raw;
    logic [15:0] px_n, py_n;
    logic [15:0] r_px, r_py, r_px3, r_py3;
    logic [31:0] r_row;
    logic [31:0] idx;

    always_comb begin
        px_raw = r_pu[32:16];
        py_raw = r_pv[31:16];
        px_n   = (px_raw >= {1'b0, lim_w}) ? 16'(px_raw - {1'b0, lim_w}) : px_raw[15:0];
        py_n   = (py_raw >= {1'b0, lim_h}) ? 16'(py_raw - {1'b0, lim_h}) : py_raw;
        idx    = r_row + {16'd0, r_px3};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f1_vld <= 1'b0;
            r_f2_vld <= 1'b0;
            r_f3_vld <= 1'b0;
            o_valid  <= 1'b0;
        end else begin
            r_f1_vld <= w_c2[CORDIC_STAGES].vld;
            r_f2_vld <= r_f1_vld;
            r_f3_vld <= r_f2_vld;
            o_valid  <= r_f3_vld;
        end
    end

    // scale, wrap and form the linear index
    always_ff @(posedge i_clk) begin
        r_pu        <= {16'd0, u} * {17'd0, lim_w};
        r_pv        <= {15'd0, v} * {17'd0, lim_h};
        r_px        <= px_n;
        r_py        <= py_n;
        r_row       <= r_py * lim_w;
        r_px3       <= r_px;
        r_py3       <= r_py;
        o_src_x     <= r_px3[12:0];
        o_src_y     <= r_py3[11:0];
        o_src_index <= idx[24:0];
    end

endmodule

// ===== sv/e2c_checker.sv =====
// port-level checks for the lookup block, bound to the top level
// depends on equirect_to_cubemap_lookup_macros.svh
`include "equirect_to_cubemap_lookup_macros.svh"

module e2c_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        start,
    input logic        busy,
    input logic        pready,
    input logic        o_valid,
    input logic [12:0] o_src_x,
    input logic [11:0] o_src_y,
    input logic [24:0] o_src_index
);

    // the pipeline never refuses a word
    `E2C_ASSERT_NOW(a_never_busy, i_clk, i_rst_n, start, !busy, "busy raised")
    // register port never waits
    `E2C_ASSERT_NOW(a_pready, i_clk, i_rst_n, 1'b1, pready, "pready dropped")
    // reset empties the result strobe
    `E2C_ASSERT_NEXT(a_rst_clear, i_clk, !i_rst_n, !o_valid, "strobe after reset")
    // on the top row the index is the column
    `E2C_ASSERT_NOW(a_row0_index, i_clk, i_rst_n, o_valid && (o_src_y == 12'd0),
        o_src_index == {12'd0, o_src_x}, "row zero index mismatch")

endmodule

bind equirect_to_cubemap_lookup e2c_checker u_e2c_checker (.*);

// ===== tb/equirect_to_cubemap_lookup_tb.sv =====
// self-checking testbench for the cubemap texel to panorama pixel lookup
// depends on e2c_pkg and equirect_to_cubemap_lookup; drives words and apb writes
module equirect_to_cubemap_lookup_tb;
    import e2c_pkg::*;

    localparam logic [1:0] REG_UNUSED = 2'd3;
    localparam longint     HALF_TURN  = 32768;
    localparam longint     FULL_TURN  = 65536;
    localparam longint     Q_HI       = 131071;
    localparam longint     Q_LO       = -131072;
    localparam int         TIMEOUT    = 400000;
    localparam int         TAIL_WAIT  = 80;

    typedef struct {
        logic [12:0] src_x;
        logic [11:0] src_y;
        logic [24:0] src_index;
    } t_pixel;

    typedef struct {
        logic [2:0]  face;
        logic [11:0] tx;
        logic [11:0] ty;
        bit          typed;
        t_pixel      pix;
    } t_row;

    logic        i_clk;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    logic [2:0]  i_face;
    logic [11:0] i_texel_x;
    logic [11:0] i_texel_y;
    logic        o_valid;
    logic [12:0] o_src_x;
    logic [11:0] o_src_y;
    logic [24:0] o_src_index;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    // register copies used for prediction
    logic [12:0] face_size_reg;
    logic [13:0] width_reg;
    logic [12:0] height_reg;

    t_pixel pending_pixels[$];
    int     mismatches;
    int     cycles;
    bit     idle_allowed;
    longint arctan_lut [16] = '{8192, 4836, 2555, 1297, 651, 326, 163, 81,
                                41, 20, 10, 5, 3, 1, 1, 0};

    equirect_to_cubemap_lookup dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_face(i_face), .i_texel_x(i_texel_x), .i_texel_y(i_texel_y),
        .o_valid(o_valid), .o_src_x(o_src_x), .o_src_y(o_src_y),
        .o_src_index(o_src_index), .psel(psel), .penable(penable),
        .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata), .prdata(prdata),
        .pready(pready)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // cycle limit
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > TIMEOUT) begin
            $display("Verification failed");
            $finish;
        end
    end

    function automatic longint sat_q(longint v);
        if (v > Q_HI) return Q_HI;
        if (v < Q_LO) return Q_LO;
        return v;
    endfunction

    function automatic longint clamp_range(longint v, longint hi);
        if (v < 1) return 1;
        if (v > hi) return hi;
        return v;
    endfunction

    // texel to q2.16 face coordinate, rounded half away from zero
    function automatic longint face_coord_q(longint t, longint n);
        longint num, mag, q;
        num = (2 * t + 1 - n) * 65536;
        mag = (num < 0) ? -num : num;
        q   = (mag + n / 2) / n;
        return sat_q((num < 0) ? -q : q);
    endfunction

    function automatic longint root_floor(longint unsigned v);
        longint unsigned res, b;
        res = 0;
        b   = 64'd1 << 62;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (v >= res + b) begin
                v   = v - (res + b);
                res = (res >> 1) + b;
            end else begin
                res = res >> 1;
            end
            b = b >> 2;
        end
        return longint'(res);
    endfunction

    // vectoring cordic, angle in 2^-16 turn
    function automatic longint angle_turns(longint y, longint x);
        longint z, xs, ys;
        z = 0;
        if (x == 0 && y == 0) return 0;
        if (x < 0) begin
            z = (y >= 0) ? HALF_TURN : -HALF_TURN;
            x = -x;
            y = -y;
        end
        for (int i = 0; i < 16; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (y >= 0) begin
                x = x + ys; y = y - xs; z = z + arctan_lut[i];
            end else begin
                x = x - ys; y = y + xs; z = z - arctan_lut[i];
            end
        end
        return z;
    endfunction

    function automatic longint clamp_turn(longint v);
        if (v < 0) return 0;
        if (v > FULL_TURN) return FULL_TURN;
        return v;
    endfunction

    // panorama pixel hit by the direction of one cubemap texel
    function automatic t_pixel predict_source_pixel(logic [2:0] face, logic [11:0] tx,
                                                    logic [11:0] ty);
        longint n, w, h, fx, fy, dx, dy, dz, r, u, v, px, py;
        t_pixel p;
        n  = clamp_range(face_size_reg, 4096);
        w  = clamp_range(width_reg, 8192);
        h  = clamp_range(height_reg, 4096);
        fx = face_coord_q(tx, n);
        fy = face_coord_q(ty, n);
        dx = 0; dy = 0; dz = 0;
        case (face)
            FACE_POS_X: begin dx = 65536;  dy = sat_q(-fy); dz = sat_q(-fx); end
            FACE_NEG_X: begin dx = -65536; dy = sat_q(-fy); dz = fx;         end
            FACE_POS_Y: begin dx = fx;     dy = 65536;      dz = fy;         end
            FACE_NEG_Y: begin dx = fx;     dy = -65536;     dz = sat_q(-fy); end
            FACE_POS_Z: begin dx = fx;     dy = sat_q(-fy); dz = 65536;      end
            FACE_NEG_Z: begin dx = sat_q(-fx); dy = sat_q(-fy); dz = -65536; end
            default: ;
        endcase
        r  = root_floor(longint'(dx * dx + dz * dz));
        u  = clamp_turn(HALF_TURN + angle_turns(dz, dx));
        v  = clamp_turn(HALF_TURN - 2 * angle_turns(dy, r));
        px = (u * w) >> 16;
        if (px >= w) px = px - w;
        py = (v * h) >> 16;
        if (py >= h) py = py - h;
        p.src_x     = px[12:0];
        p.src_y     = py[11:0];
        p.src_index = 25'(py * w + px);
        return p;
    endfunction

    // result checker
    always @(posedge i_clk) begin
        t_pixel e;
        if (i_rst_n && o_valid) begin
            if (pending_pixels.size() == 0) begin
                mismatches <= mismatches + 1;
                if (mismatches < 10)
                    $display("unexpected word x=%0d y=%0d idx=%0d",
                             o_src_x, o_src_y, o_src_index);
            end else begin
                e = pending_pixels.pop_front();
                if (o_src_x !== e.src_x || o_src_y !== e.src_y
                        || o_src_index !== e.src_index) begin
                    mismatches <= mismatches + 1;
                    if (mismatches < 10)
                        $display("mismatch exp x=%0d y=%0d idx=%0d got x=%0d y=%0d idx=%0d",
                                 e.src_x, e.src_y, e.src_index,
                                 o_src_x, o_src_y, o_src_index);
                end
            end
        end
    end

    // apb write, setup then access
    task automatic reg_write(logic [1:0] idx, logic [31:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(negedge i_clk); while (!pready);
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_FACE_SIZE:   face_size_reg = val[12:0];
            REG_PANO_WIDTH:  width_reg     = val[13:0];
            REG_PANO_HEIGHT: height_reg    = val[12:0];
            default: ;
        endcase
    endtask

    task automatic drain();
        start <= 1'b0;
        while (pending_pixels.size() != 0) @(posedge i_clk);
        repeat (3) @(posedge i_clk);
    endtask

    task automatic set_sizes(logic [31:0] n, logic [31:0] w, logic [31:0] h);
        drain();
        reg_write(REG_FACE_SIZE, n);
        reg_write(REG_PANO_WIDTH, w);
        reg_write(REG_PANO_HEIGHT, h);
    endtask

    // hand one word over; start stays high between back-to-back words
    task automatic send_word(logic [2:0] face, logic [11:0] tx, logic [11:0] ty,
                             bit typed, t_pixel typed_pix);
        bit taken;
        if (idle_allowed && $urandom_range(0, 3) == 0) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge i_clk);
        end
        start     <= 1'b1;
        i_face    <= face;
        i_texel_x <= tx;
        i_texel_y <= ty;
        do begin
            @(negedge i_clk);
            taken = !busy;
            @(posedge i_clk);
        end while (!taken);
        pending_pixels.push_back(typed ? typed_pix : predict_source_pixel(face, tx, ty));
    endtask

    task automatic random_words(int count);
        longint n;
        logic [2:0]  face;
        logic [11:0] tx, ty;
        t_pixel none;
        none = '{default: '0};
        n = clamp_range(face_size_reg, 4096);
        for (int k = 0; k < count; k++) begin
            face = ($urandom_range(0, 15) == 0) ? 3'($urandom_range(6, 7))
                                                 : 3'($urandom_range(0, 5));
            if ($urandom_range(0, 6) == 0) begin
                tx = 12'($urandom);
                ty = 12'($urandom);
            end else begin
                tx = 12'($urandom_range(0, n - 1));
                ty = 12'($urandom_range(0, n - 1));
            end
            send_word(face, tx, ty, 1'b0, none);
        end
    endtask

    // directed words at reset sizes; typed rows are the panorama centre
    t_row directed [] = '{
        '{FACE_POS_X, 12'd0,    12'd0,    1'b0, '{0, 0, 0}},
        '{FACE_POS_X, 12'd511,  12'd511,  1'b0, '{0, 0, 0}},
        '{FACE_NEG_X, 12'd0,    12'd511,  1'b0, '{0, 0, 0}},
        '{FACE_NEG_X, 12'd255,  12'd256,  1'b0, '{0, 0, 0}},
        '{FACE_POS_Y, 12'd0,    12'd0,    1'b0, '{0, 0, 0}},
        '{FACE_POS_Y, 12'd256,  12'd256,  1'b0, '{0, 0, 0}},
        '{FACE_NEG_Y, 12'd511,  12'd0,    1'b0, '{0, 0, 0}},
        '{FACE_NEG_Y, 12'd255,  12'd255,  1'b0, '{0, 0, 0}},
        '{FACE_POS_Z, 12'd0,    12'd511,  1'b0, '{0, 0, 0}},
        '{FACE_POS_Z, 12'd255,  12'd255,  1'b0, '{0, 0, 0}},
        '{FACE_NEG_Z, 12'd511,  12'd0,    1'b0, '{0, 0, 0}},
        '{FACE_NEG_Z, 12'd256,  12'd255,  1'b0, '{0, 0, 0}},
        '{3'd6,       12'd0,    12'd0,    1'b1, '{13'd1024, 12'd512, 25'd1049600}},
        '{3'd7,       12'd4095, 12'd4095, 1'b1, '{13'd1024, 12'd512, 25'd1049600}},
        '{FACE_POS_X, 12'd4095, 12'd4095, 1'b0, '{0, 0, 0}},
        '{FACE_NEG_Z, 12'd4095, 12'd0,    1'b0, '{0, 0, 0}},
        '{FACE_POS_Y, 12'd4095, 12'd4095, 1'b0, '{0, 0, 0}},
        '{FACE_NEG_Y, 12'd0,    12'd4095, 1'b0, '{0, 0, 0}},
        '{FACE_POS_Z, 12'd2730, 12'd1365, 1'b0, '{0, 0, 0}},
        '{FACE_NEG_X, 12'd1365, 12'd2730, 1'b0, '{0, 0, 0}}
    };

    // main sequence
    initial begin
        i_rst_n      = 1'b0;
        start        = 1'b0;
        i_face       = '0;
        i_texel_x    = '0;
        i_texel_y    = '0;
        psel         = 1'b0;
        penable      = 1'b0;
        pwrite       = 1'b0;
        paddr        = '0;
        pwdata       = '0;
        mismatches   = 0;
        cycles       = 0;
        idle_allowed = 1'b1;
        face_size_reg = 13'd512;
        width_reg     = 14'd2048;
        height_reg    = 13'd1024;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed[k])
            send_word(directed[k].face, directed[k].tx, directed[k].ty,
                      directed[k].typed, directed[k].pix);

        // size extremes, out-of-range values and an unmapped register
        set_sizes(32'd1, 32'd1, 32'd1);
        random_words(60);
        set_sizes(32'd4096, 32'd8192, 32'd4096);
        random_words(110);
        set_sizes(32'hFFFF_0000, 32'h0000_C000, 32'h0000_E000);
        random_words(60);
        set_sizes(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        reg_write(REG_UNUSED, 32'h0000_0007);
        random_words(110);
        for (int ph = 0; ph < 4; ph++) begin
            set_sizes($urandom_range(1, 600), $urandom_range(1, 8192),
                      $urandom_range(1, 4096));
            random_words(75);
        end
        set_sizes($urandom_range(1, 4096), $urandom_range(1, 8192),
                  $urandom_range(1, 4096));
        random_words(60);

        // closing stretch with no gaps
        idle_allowed = 1'b0;
        set_sizes(32'd512, 32'd2048, 32'd1024);
        random_words(50);
        start <= 1'b0;

        while (pending_pixels.size() != 0) @(posedge i_clk);
        repeat (TAIL_WAIT) @(posedge i_clk);
        if (mismatches == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
